[hdl/lpfl_pkg.sv]
// ----------------------------------------------------------------------------
// lpfl_pkg
// Shared widths, defaults and codes of the linked page free-list manager.
// ----------------------------------------------------------------------------
package lpfl_pkg;

    localparam int OP_W     = 2;
    localparam int SEG_W    = 6;
    localparam int STATUS_W = 2;
    localparam int PAGE_W   = 10;
    localparam int CNT_W    = 11;

    localparam int NUM_PAGES_DEF    = 1024;
    localparam int NUM_SEGMENTS_DEF = 64;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND  = 2'd0,
        OP_POP     = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_NOFREE = 2'd1,
        ST_EMPTY  = 2'd2
    } t_status;

endpackage

[hdl/lpfl_req_if.sv]
// ----------------------------------------------------------------------------
// lpfl_req_if
// Request channel: operation code and segment index, valid/ready transfer.
// ----------------------------------------------------------------------------
interface lpfl_req_if
    import lpfl_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [SEG_W-1:0] segment;

    modport source (output valid, output op, output segment, input ready);
    modport sink   (input valid, input op, input segment, output ready);
endinterface

[hdl/lpfl_rsp_if.sv]
// ----------------------------------------------------------------------------
// lpfl_rsp_if
// Response channel: status, page, pages freed and free count per operation.
// ----------------------------------------------------------------------------
interface lpfl_rsp_if
    import lpfl_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   page;
    logic [CNT_W-1:0]    freed_pages;
    logic [CNT_W-1:0]    free_count;

    modport source (output valid, output status, output page, output freed_pages,
                    output free_count, input ready);
    modport sink   (input valid, input status, input page, input freed_pages,
                    input free_count, output ready);
endinterface

[hdl/linked_page_free_list_manager.sv]
// ----------------------------------------------------------------------------
// linked_page_free_list_manager
// Page pool with one free list and per-segment page chains in a link table.
// ----------------------------------------------------------------------------
// After reset the block sweeps the link table, one entry per cycle, and takes
// no request until the sweep is done. Then one request is handled at a time:
// the request is taken, the segment and link tables are read in the next
// cycle, and append, a bad segment, an empty chain or a no-op finishes there.
// Pop and release go on to walk the chain through the single read port of
// the link table, one page per cycle; pop frees the head page and release
// the whole chain, stopping at its tail or after NUM_PAGES pages.
// A result may wait in the output register while the next request is taken;
// if it still waits when that request finishes, the block holds until the
// output register frees.
module linked_page_free_list_manager
    import lpfl_pkg::*;
#(
    parameter int NUM_PAGES    = NUM_PAGES_DEF,
    parameter int NUM_SEGMENTS = NUM_SEGMENTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpfl_req_if.sink    i_req,
    lpfl_rsp_if.source  o_rsp
);

    localparam int PAW = $clog2(NUM_PAGES);
    localparam int CW  = $clog2(NUM_PAGES + 1);
    localparam int SAW = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_HOLD
    } t_state;

    function automatic logic [PAW-1:0] clamp_page(input logic [PAW-1:0] v);
        clamp_page = ({1'b0, v} < (PAW+1)'(NUM_PAGES)) ? v : '0;
    endfunction

    t_state                r_state, n_state;
    logic [PAW-1:0]        r_idx, n_idx;
    logic [PAW-1:0]        r_free_head, n_free_head;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [NUM_SEGMENTS-1:0] r_valid, n_valid;
    t_op                   r_op, n_op;
    logic [SEG_W-1:0]      r_seg, n_seg;
    logic [PAW-1:0]        r_cur, n_cur;
    logic [PAW-1:0]        r_tail, n_tail;
    logic [CW-1:0]         r_freed, n_freed;

    logic                  r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]   r_out_status, n_out_status;
    logic [PAGE_W-1:0]     r_out_page, n_out_page;
    logic [CNT_W-1:0]      r_out_freed, n_out_freed;
    logic [CNT_W-1:0]      r_out_count, n_out_count;

    logic [STATUS_W-1:0]   r_res_status, n_res_status;
    logic [PAGE_W-1:0]     r_res_page, n_res_page;
    logic [CNT_W-1:0]      r_res_freed, n_res_freed;
    logic [CNT_W-1:0]      r_res_count, n_res_count;

    logic                  link_we;
    logic [PAW-1:0]        link_waddr, link_wdata, link_raddr, link_rdata;
    logic                  head_we, tail_we;
    logic [PAW-1:0]        head_wdata, tail_wdata, head_rdata, tail_rdata;
    logic [SAW-1:0]        seg_raddr, seg_idx;

    logic [SEG_W+SAW-1:0]  in_seg_x, r_seg_x;
    logic                  seg_ok, seg_valid;
    logic [PAW-1:0]        link_c, head_c;
    logic                  out_free, is_last;

    logic                  fin;
    t_status               f_status;
    logic [PAW-1:0]        f_page;
    logic [CW-1:0]         f_freed;
    logic [PAGE_W+PAW-1:0] f_page_x;
    logic [CNT_W+CW-1:0]   f_freed_x, f_count_x;

    assign in_seg_x  = (SEG_W+SAW)'(i_req.segment);
    assign seg_raddr = in_seg_x[SAW-1:0];
    assign r_seg_x   = (SEG_W+SAW)'(r_seg);
    assign seg_idx   = r_seg_x[SAW-1:0];
    assign seg_ok    = r_seg_x < (SEG_W+SAW)'(NUM_SEGMENTS);
    assign seg_valid = seg_ok && r_valid[seg_idx];
    assign link_c    = clamp_page(link_rdata);
    assign head_c    = clamp_page(head_rdata);
    assign out_free  = !r_out_valid || o_rsp.ready;
    assign is_last   = (r_cur == r_tail);

    assign f_page_x  = (PAGE_W+PAW)'(f_page);
    assign f_freed_x = (CNT_W+CW)'(f_freed);
    assign f_count_x = (CNT_W+CW)'(n_cnt);

    lpfl_ram #(.DEPTH(NUM_PAGES), .DATA_W(PAW)) u_link (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    lpfl_ram #(.DEPTH(NUM_SEGMENTS), .DATA_W(PAW)) u_head (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (seg_idx),
        .i_wdata (head_wdata),
        .i_raddr (seg_raddr),
        .o_rdata (head_rdata)
    );

    lpfl_ram #(.DEPTH(NUM_SEGMENTS), .DATA_W(PAW)) u_tail (
        .i_clk   (i_clk),
        .i_we    (tail_we),
        .i_waddr (seg_idx),
        .i_wdata (tail_wdata),
        .i_raddr (seg_raddr),
        .o_rdata (tail_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_free_head  = r_free_head;
        n_cnt        = r_cnt;
        n_valid      = r_valid;
        n_op         = r_op;
        n_seg        = r_seg;
        n_cur        = r_cur;
        n_tail       = r_tail;
        n_freed      = r_freed;
        n_res_status = r_res_status;
        n_res_page   = r_res_page;
        n_res_freed  = r_res_freed;
        n_res_count  = r_res_count;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_page   = r_out_page;
        n_out_freed  = r_out_freed;
        n_out_count  = r_out_count;

        link_we    = 1'b0;
        link_waddr = r_cur;
        link_wdata = r_free_head;
        link_raddr = r_free_head;
        head_we    = 1'b0;
        head_wdata = link_c;
        tail_we    = 1'b0;
        tail_wdata = r_free_head;

        fin      = 1'b0;
        f_status = ST_OK;
        f_page   = '0;
        f_freed  = '0;

        unique case (r_state)
            S_INIT: begin
                link_we    = 1'b1;
                link_waddr = r_idx;
                link_wdata = (r_idx == PAW'(NUM_PAGES - 1)) ? '0 : r_idx + PAW'(1);
                n_idx      = r_idx + PAW'(1);
                if (r_idx == PAW'(NUM_PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op    = t_op'(i_req.op);
                    n_seg   = i_req.segment;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_freed = '0;
                n_cur   = head_c;
                n_tail  = tail_rdata;
                link_raddr = head_c;
                if (!seg_ok) begin
                    fin      = 1'b1;
                    f_status = ST_EMPTY;
                end else begin
                    unique case (r_op)
                        OP_APPEND: begin
                            fin = 1'b1;
                            if (r_cnt == '0) begin
                                f_status = ST_NOFREE;
                            end else begin
                                n_free_head = link_c;
                                n_cnt       = r_cnt - CW'(1);
                                tail_we     = 1'b1;
                                if (seg_valid) begin
                                    link_we    = 1'b1;
                                    link_waddr = clamp_page(tail_rdata);
                                end else begin
                                    head_we    = 1'b1;
                                    head_wdata = r_free_head;
                                    n_valid[seg_idx] = 1'b1;
                                end
                                f_page = r_free_head;
                            end
                        end
                        OP_POP: begin
                            if (!seg_valid) begin
                                fin      = 1'b1;
                                f_status = ST_EMPTY;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        OP_RELEASE: begin
                            if (!seg_valid) begin
                                fin = 1'b1;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        OP_NOP: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_WALK: begin
                link_we     = 1'b1;
                link_waddr  = r_cur;
                link_raddr  = link_c;
                n_free_head = r_cur;
                n_cnt       = r_cnt + CW'(1);
                n_freed     = r_freed + CW'(1);
                n_cur       = link_c;
                f_freed     = n_freed;
                if (is_last) begin
                    n_valid[seg_idx] = 1'b0;
                end else if (r_op == OP_POP) begin
                    head_we = 1'b1;
                end
                if (is_last || r_op == OP_POP || n_freed == CW'(NUM_PAGES)) begin
                    fin = 1'b1;
                    if (r_op == OP_POP) begin
                        f_page = r_cur;
                    end else begin
                        n_valid[seg_idx] = 1'b0;
                    end
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_page   = r_res_page;
                    n_out_freed  = r_res_freed;
                    n_out_count  = r_res_count;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase

        if (fin) begin
            if (out_free) begin
                n_out_valid  = 1'b1;
                n_out_status = f_status;
                n_out_page   = f_page_x[PAGE_W-1:0];
                n_out_freed  = f_freed_x[CNT_W-1:0];
                n_out_count  = f_count_x[CNT_W-1:0];
                n_state      = S_IDLE;
            end else begin
                n_res_status = f_status;
                n_res_page   = f_page_x[PAGE_W-1:0];
                n_res_freed  = f_freed_x[CNT_W-1:0];
                n_res_count  = f_count_x[CNT_W-1:0];
                n_state      = S_HOLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_idx       <= '0;
            r_free_head <= '0;
            r_cnt       <= CW'(NUM_PAGES);
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_free_head <= n_free_head;
            r_cnt       <= n_cnt;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
        r_op         <= n_op;
        r_seg        <= n_seg;
        r_cur        <= n_cur;
        r_tail       <= n_tail;
        r_freed      <= n_freed;
        r_res_status <= n_res_status;
        r_res_page   <= n_res_page;
        r_res_freed  <= n_res_freed;
        r_res_count  <= n_res_count;
        r_out_status <= n_out_status;
        r_out_page   <= n_out_page;
        r_out_freed  <= n_out_freed;
        r_out_count  <= n_out_count;
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.page        = r_out_page;
    assign o_rsp.freed_pages = r_out_freed;
    assign o_rsp.free_count  = r_out_count;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(NUM_PAGES))
        else $error("free count above pool size");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == S_DECODE))
        else $error("transfer not followed by decode");

    a_walk_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |=> (r_cnt == $past(r_cnt) + CW'(1)))
        else $error("walk step did not free one page");

    a_walk_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && r_cnt != '0) |-> (r_cur != r_free_head))
        else $error("chain page already on free list");
`endif

endmodule

[hdl/lpfl_ram.sv]
// ----------------------------------------------------------------------------
// lpfl_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lpfl_ram #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 10,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Checks the linked page free-list manager against a predictor of its pool.
// A directed table covers reset values, the full-pool count, every opcode and
// the chain-empty status. Random traffic follows: mixed ops on a few hot segments,
// then a pass that builds one long chain in a single segment and releases it
// whole. Every response transfer is compared field by field with the oldest
// prediction. Sender bursts and receiver stall patterns vary over the run.
// ----------------------------------------------------------------------------
module tb_top;
    import lpfl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PAGES    = NUM_PAGES_DEF;
    localparam int NUM_SEGMENTS = NUM_SEGMENTS_DEF;
    localparam int MIXED_ITEMS  = 250;
    localparam int FILL_PAGES   = 240;
    localparam int SETTLE_CYC   = 40;

    typedef struct packed {
        t_status          status;
        logic [PAGE_W-1:0] page;
        logic [CNT_W-1:0]  freed;
        logic [CNT_W-1:0]  free_cnt;
    } outcome_t;

    typedef struct packed {
        t_op              op;
        logic [SEG_W-1:0] seg;
        logic             typed;
        outcome_t         res;
    } dir_row_t;

    localparam int DIR_ROWS = 23;
    localparam dir_row_t DIR_TBL [DIR_ROWS] = '{
        '{OP_APPEND,  6'd0,  1'b1, '{ST_OK,    10'd0, 11'd0, 11'd1023}},
        '{OP_APPEND,  6'd0,  1'b1, '{ST_OK,    10'd1, 11'd0, 11'd1022}},
        '{OP_APPEND,  6'd63, 1'b1, '{ST_OK,    10'd2, 11'd0, 11'd1021}},
        '{OP_POP,     6'd0,  1'b1, '{ST_OK,    10'd0, 11'd1, 11'd1022}},
        '{OP_POP,     6'd5,  1'b1, '{ST_EMPTY, 10'd0, 11'd0, 11'd1022}},
        '{OP_RELEASE, 6'd7,  1'b1, '{ST_OK,    10'd0, 11'd0, 11'd1022}},
        '{OP_NOP,     6'd63, 1'b1, '{ST_OK,    10'd0, 11'd0, 11'd1022}},
        '{OP_RELEASE, 6'd0,  1'b1, '{ST_OK,    10'd0, 11'd1, 11'd1023}},
        '{OP_POP,     6'd63, 1'b1, '{ST_OK,    10'd2, 11'd1, 11'd1024}},
        '{OP_POP,     6'd63, 1'b1, '{ST_EMPTY, 10'd0, 11'd0, 11'd1024}},
        '{OP_APPEND,  6'd42, 1'b0, '0},
        '{OP_APPEND,  6'd42, 1'b0, '0},
        '{OP_APPEND,  6'd42, 1'b0, '0},
        '{OP_APPEND,  6'd21, 1'b0, '0},
        '{OP_POP,     6'd42, 1'b0, '0},
        '{OP_APPEND,  6'd42, 1'b0, '0},
        '{OP_RELEASE, 6'd42, 1'b0, '0},
        '{OP_NOP,     6'd0,  1'b0, '0},
        '{OP_APPEND,  6'd63, 1'b0, '0},
        '{OP_RELEASE, 6'd63, 1'b0, '0},
        '{OP_POP,     6'd21, 1'b0, '0},
        '{OP_APPEND,  6'd21, 1'b0, '0},
        '{OP_APPEND,  6'd42, 1'b0, '0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    lpfl_req_if req_if ();
    lpfl_rsp_if rsp_if ();

    linked_page_free_list_manager #(
        .NUM_PAGES    (NUM_PAGES),
        .NUM_SEGMENTS (NUM_SEGMENTS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #5 i_clk = ~i_clk;

    // predicted pool state
    logic [PAGE_W-1:0] link_tbl   [NUM_PAGES];
    logic [PAGE_W-1:0] chain_head [NUM_SEGMENTS];
    logic [PAGE_W-1:0] chain_tail [NUM_SEGMENTS];
    logic              chain_live [NUM_SEGMENTS];
    logic [PAGE_W-1:0] free_head;
    logic [CNT_W-1:0]  free_cnt;

    outcome_t pending_outcomes [$];

    int errors       = 0;
    int n_results    = 0;
    int n_nofree     = 0;
    int n_empty      = 0;
    int max_freed    = 0;
    int op_count [4] = '{0, 0, 0, 0};
    int burst_left   = 0;

    function automatic void free_chain_head(input logic [SEG_W-1:0] seg);
        logic [PAGE_W-1:0] pg;
        pg = chain_head[seg];
        if (pg == chain_tail[seg]) begin
            chain_live[seg] = 1'b0;
        end else begin
            chain_head[seg] = link_tbl[pg];
        end
        link_tbl[pg] = free_head;
        free_head    = pg;
        free_cnt     = free_cnt + 1'b1;
    endfunction

    function automatic outcome_t page_op_outcome(input t_op op, input logic [SEG_W-1:0] seg);
        outcome_t          o;
        logic [PAGE_W-1:0] np;
        o        = '0;
        o.status = ST_OK;
        if (int'(seg) >= NUM_SEGMENTS) begin
            o.status = ST_EMPTY;
        end else begin
            case (op)
                OP_APPEND: begin
                    if (free_cnt == 0) begin
                        o.status = ST_NOFREE;
                    end else begin
                        np        = free_head;
                        free_head = link_tbl[np];
                        free_cnt  = free_cnt - 1'b1;
                        if (chain_live[seg]) begin
                            link_tbl[chain_tail[seg]] = np;
                        end else begin
                            chain_head[seg] = np;
                            chain_live[seg] = 1'b1;
                        end
                        chain_tail[seg] = np;
                        o.page          = np;
                    end
                end
                OP_POP: begin
                    if (!chain_live[seg]) begin
                        o.status = ST_EMPTY;
                    end else begin
                        o.page  = chain_head[seg];
                        free_chain_head(seg);
                        o.freed = 11'd1;
                    end
                end
                OP_RELEASE: begin
                    while (chain_live[seg] && int'(o.freed) < NUM_PAGES) begin
                        free_chain_head(seg);
                        o.freed = o.freed + 1'b1;
                    end
                    chain_live[seg] = 1'b0;
                end
                default: ;
            endcase
        end
        o.free_cnt = free_cnt;
        return o;
    endfunction

    task automatic report(input string field, input int got, input int want);
        errors++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    endtask

    // transfer one request, predict it, then idle per the burst pattern
    task automatic issue(input t_op op, input logic [SEG_W-1:0] seg,
                         input logic typed, input outcome_t typed_res);
        outcome_t pred;
        int       gap;
        req_if.valid   <= 1'b1;
        req_if.op      <= op;
        req_if.segment <= seg;
        do @(posedge i_clk); while (!req_if.ready);
        pred = page_op_outcome(op, seg);
        pending_outcomes.push_back(typed ? typed_res : pred);
        op_count[op]++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [SEG_W-1:0] pick_segment();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return SEG_W'($urandom_range(0, 3));
        if (r < 60) return ($urandom_range(0, 1) != 0) ? SEG_W'(NUM_SEGMENTS - 1) : '0;
        return SEG_W'($urandom_range(0, NUM_SEGMENTS - 1));
    endfunction

    task automatic mixed_traffic(input int count);
        int  r;
        t_op op;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 50)      op = OP_APPEND;
            else if (r < 75) op = OP_POP;
            else if (r < 92) op = OP_RELEASE;
            else             op = OP_NOP;
            issue(op, pick_segment(), 1'b0, '0);
        end
    endtask

    // receiver: switch at random between stall patterns
    int       rx_mode      = 0;
    int       rx_mode_left = 0;
    int       rx_hold      = 0;
    bit [1:0] rx_phase     = '0;

    always @(posedge i_clk) begin
        rx_phase <= rx_phase + 1'b1;
        if (rx_mode_left == 0) begin
            rx_mode      <= $urandom_range(0, 3);
            rx_mode_left <= $urandom_range(30, 200);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= 1'($urandom_range(0, 1));
            2: rsp_if.ready <= (rx_phase != 2'd0);
            default: begin
                if (rx_hold != 0) begin
                    rx_hold      <= rx_hold - 1;
                    rsp_if.ready <= 1'b0;
                end else begin
                    rsp_if.ready <= 1'b1;
                    if ($urandom_range(0, 5) == 0) rx_hold <= $urandom_range(3, 12);
                end
            end
        endcase
    end

    always @(posedge i_clk) begin : rsp_check
        outcome_t want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            n_results++;
            if (rsp_if.status == ST_NOFREE) n_nofree++;
            if (rsp_if.status == ST_EMPTY) n_empty++;
            if (int'(rsp_if.freed_pages) > max_freed) max_freed = int'(rsp_if.freed_pages);
            if (pending_outcomes.size() == 0) begin
                report("unexpected response", int'(rsp_if.status), -1);
            end else begin
                want = pending_outcomes.pop_front();
                if (rsp_if.status !== want.status)
                    report("status", int'(rsp_if.status), int'(want.status));
                if (rsp_if.page !== want.page)
                    report("page", int'(rsp_if.page), int'(want.page));
                if (rsp_if.freed_pages !== want.freed)
                    report("freed_pages", int'(rsp_if.freed_pages), int'(want.freed));
                if (rsp_if.free_count !== want.free_cnt)
                    report("free_count", int'(rsp_if.free_count), int'(want.free_cnt));
            end
        end
    end

    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        logic [SEG_W-1:0] fill_seg;
        logic [SEG_W-1:0] other_seg;

        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.op      = OP_NOP;
        req_if.segment = '0;
        rsp_if.ready   = 1'b0;

        for (int i = 0; i < NUM_PAGES; i++) link_tbl[i] = PAGE_W'((i + 1) % NUM_PAGES);
        for (int i = 0; i < NUM_SEGMENTS; i++) begin
            chain_head[i] = '0;
            chain_tail[i] = '0;
            chain_live[i] = 1'b0;
        end
        free_head = '0;
        free_cnt  = CNT_W'(NUM_PAGES);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++)
            issue(DIR_TBL[i].op, DIR_TBL[i].seg, DIR_TBL[i].typed, DIR_TBL[i].res);
        drain();

        mixed_traffic(MIXED_ITEMS);
        drain();

        // empty every chain, then build one long chain in a single segment
        for (int s = 0; s < NUM_SEGMENTS; s++) issue(OP_RELEASE, SEG_W'(s), 1'b0, '0);
        fill_seg  = SEG_W'($urandom_range(0, NUM_SEGMENTS - 1));
        other_seg = fill_seg ^ SEG_W'($urandom_range(1, NUM_SEGMENTS - 1));
        for (int n = 0; n < FILL_PAGES; n++) issue(OP_APPEND, fill_seg, 1'b0, '0);
        issue(OP_APPEND, fill_seg, 1'b0, '0);
        issue(OP_APPEND, other_seg, 1'b0, '0);
        issue(OP_POP, other_seg, 1'b0, '0);
        issue(OP_POP, fill_seg, 1'b0, '0);
        issue(OP_APPEND, other_seg, 1'b0, '0);
        issue(OP_APPEND, fill_seg, 1'b0, '0);
        issue(OP_RELEASE, other_seg, 1'b0, '0);
        issue(OP_RELEASE, fill_seg, 1'b0, '0);
        drain();

        mixed_traffic(MIXED_ITEMS);
        drain();
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("covered %0d appends, %0d pops, %0d releases, %0d no-ops",
                 op_count[OP_APPEND], op_count[OP_POP], op_count[OP_RELEASE], op_count[OP_NOP]);
        $display("%0d responses: %0d pool-empty, %0d chain-empty, largest release %0d pages",
                 n_results, n_nofree, n_empty, max_freed);
        if (errors == 0 && pending_outcomes.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[linked_page_free_list_manager.f]
hdl/lpfl_pkg.sv
hdl/lpfl_req_if.sv
hdl/lpfl_rsp_if.sv
hdl/lpfl_ram.sv
hdl/linked_page_free_list_manager.sv
sim/tb_top.sv
